>>> src/avc_sps_picture_size_parser_core_macros.svh
// Assertion macros for the SPS picture size parser.
// Included by the top level only; no other dependencies.
`ifndef AVC_SPS_PICTURE_SIZE_PARSER_CORE_MACROS_SVH
`define AVC_SPS_PICTURE_SIZE_PARSER_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define SPS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sps parser: forbidden condition seen");

// Antecedent must imply consequent in the same cycle.
`define SPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sps parser: implication failed");

`endif

>>> src/sps_size_pkg.sv
// Shared constants, types and helper functions of the SPS picture size parser.
// No dependencies.
package sps_size_pkg;

   localparam int RBSP_BYTES        = 512;
   localparam int POC_CYCLE_LIMIT   = 256;
   localparam int GOLOMB_ZERO_LIMIT = 32;

   localparam int SEEN_W = $clog2(RBSP_BYTES + 1);
   localparam int CYC_W  = $clog2(POC_CYCLE_LIMIT + 1);
   localparam int ZERO_W = $clog2(GOLOMB_ZERO_LIMIT + 1);
   localparam int SIZE_W = 37;

   localparam int LISTS_444      = 12;
   localparam int LISTS_OTHER    = 8;
   localparam int SMALL_LISTS    = 6;
   localparam int SMALL_LIST_LEN = 16;
   localparam int LARGE_LIST_LEN = 64;
   localparam int SCALE_DEFAULT  = 8;
   localparam int MIN_NAL_BYTES  = 4;

   localparam logic [7:0] EPB_BYTE = 8'h03;

   localparam logic [7:0] PROF_HIGH     = 8'd100;
   localparam logic [7:0] PROF_HIGH10   = 8'd110;
   localparam logic [7:0] PROF_HIGH422  = 8'd122;
   localparam logic [7:0] PROF_HIGH444  = 8'd244;
   localparam logic [7:0] PROF_CAVLC444 = 8'd44;
   localparam logic [7:0] PROF_SCAL_B   = 8'd83;
   localparam logic [7:0] PROF_SCAL_H   = 8'd86;
   localparam logic [7:0] PROF_MV_H     = 8'd118;
   localparam logic [7:0] PROF_STEREO_H = 8'd128;
   localparam logic [7:0] PROF_MVCD     = 8'd138;
   localparam logic [7:0] PROF_MVCD3    = 8'd139;
   localparam logic [7:0] PROF_MFC_H    = 8'd134;

   typedef enum logic [4:0] {
      PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_SEPCOL,
      PH_BDLUMA, PH_BDCHROMA, PH_BYPASS, PH_SMPRESENT, PH_LISTFLAG, PH_DELTA,
      PH_LOG2FN, PH_POCTYPE, PH_POCLSB, PH_POCFLAG, PH_POCNONREF, PH_POCT2B,
      PH_POCCYC, PH_POCOFF, PH_MAXREF, PH_GAPS, PH_WMBS, PH_HMAP, PH_FRAMEONLY,
      PH_MBAFF, PH_DIRECT8, PH_CROPFLAG, PH_CROP, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CALC_IDLE, CALC_SUB, CALC_CHECK
   } calc_state_type;

   typedef struct packed {
      logic valid;
      logic data;
      logic last;
   } bit_beat_type;

   typedef struct packed {
      logic              done;
      logic              sep_plane;
      logic              cf_zero;
      logic              cf_one;
      logic              cf_three;
      logic              frame_only;
      logic [31:0]       width_in_mbs;
      logic [31:0]       height_in_map_units;
      logic [3:0][31:0]  crop_offsets;
   } sps_fields_type;

   function automatic logic is_high_profile(input logic [7:0] p);
      return p == PROF_HIGH || p == PROF_HIGH10 || p == PROF_HIGH422 ||
             p == PROF_HIGH444 || p == PROF_CAVLC444 || p == PROF_SCAL_B ||
             p == PROF_SCAL_H || p == PROF_MV_H || p == PROF_STEREO_H ||
             p == PROF_MVCD || p == PROF_MVCD3 || p == PROF_MFC_H;
   endfunction

   // Signed exp-Golomb mapping, low 8 bits only.
   function automatic logic [7:0] se_mod256(input logic [8:0] v);
      logic [9:0] t;
      t = {1'b0, v} + 10'd1;
      if (v[0]) begin
         return t[8:1];
      end else begin
         return 8'(8'd0 - v[8:1]);
      end
   endfunction

endpackage

>>> src/sps_size_if.sv
// Handshake channels of the SPS picture size parser: NAL byte in, size out.
// No dependencies.
interface sps_size_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] nal_byte;
   logic       last_byte;
   modport source (output valid, output nal_byte, output last_byte, input ready);
   modport sink (input valid, input nal_byte, input last_byte, output ready);
endinterface

interface sps_size_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pic_width;
   logic [15:0] pic_height;
   logic        size_ok;
   modport source (output valid, output pic_width, output pic_height, output size_ok,
                   input ready);
   modport sink (input valid, input pic_width, input pic_height, input size_ok,
                 output ready);
endinterface

>>> src/sps_size_rbsp.sv
// Byte intake: header skip, emulation prevention removal, held byte, bit shifter.
// Depends on sps_size_pkg.
module sps_size_rbsp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 nal_byte,
   input  logic                       last_byte,
   input  logic                       parser_done,
   input  logic                       calc_ready,
   output logic                       busy,
   output logic                       nal_end,
   output logic                       short_ok,
   output sps_size_pkg::bit_beat_type beat
);
   import sps_size_pkg::*;

   logic [2:0]        raw_cnt_ff, raw_cnt_in;
   logic [1:0]        zero_run_ff, zero_run_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [7:0]        held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic              data_end_ff, data_end_in;
   logic [15:0]       shift_ff, shift_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              final_ff, final_in;
   logic              flush_ff, flush_in;

   logic              live, epb, keep;
   logic [1:0]        nq;
   logic [15:0]       q;

   assign busy     = (cnt_ff != 5'd0) || flush_ff;
   assign nal_end  = flush_ff && (cnt_ff == 5'd0) && parser_done && calc_ready;
   assign short_ok = raw_cnt_ff >= 3'(MIN_NAL_BYTES);

   always_comb begin
      beat.valid = (cnt_ff != 5'd0) || (flush_ff && !parser_done);
      beat.data  = (cnt_ff != 5'd0) ? shift_ff[15] : 1'b0;
      beat.last  = (cnt_ff != 5'd0) ? (final_ff && cnt_ff == 5'd1) : 1'b1;
   end

   always_comb begin
      raw_cnt_in    = raw_cnt_ff;
      zero_run_in   = zero_run_ff;
      seen_in       = seen_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      data_end_in   = data_end_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      final_in      = final_ff;
      flush_in      = flush_ff;
      live          = (raw_cnt_ff != 3'd0) && !data_end_ff;
      epb           = (zero_run_ff >= 2'd2) && (nal_byte == EPB_BYTE);
      keep          = live && !epb;
      nq            = 2'd0;
      q             = 16'd0;

      if (cnt_ff != 5'd0) begin
         // advance one bit toward the parser
         shift_in = {shift_ff[14:0], 1'b0};
         cnt_in   = cnt_ff - 5'd1;
      end

      if (accept) begin
         if (raw_cnt_ff < 3'(MIN_NAL_BYTES)) begin
            raw_cnt_in = raw_cnt_ff + 3'd1;
         end
         if (live) begin
            if (epb) begin
               zero_run_in = 2'd0;
            end else if (nal_byte == 8'd0) begin
               zero_run_in = (zero_run_ff < 2'd2) ? zero_run_ff + 2'd1 : 2'd2;
            end else begin
               zero_run_in = 2'd0;
            end
         end
         final_in = 1'b0;
         if (keep) begin
            if (held_valid_ff) begin
               q[15:8] = held_ff;
               nq      = 2'd1;
            end
            seen_in = seen_ff + SEEN_W'(1);
            if (seen_in >= SEEN_W'(RBSP_BYTES)) begin
               // payload full: push this byte too and close the stream
               if (nq == 2'd0) begin
                  q[15:8] = nal_byte;
               end else begin
                  q[7:0] = nal_byte;
               end
               nq            = nq + 2'd1;
               final_in      = 1'b1;
               held_valid_in = 1'b0;
               data_end_in   = 1'b1;
            end else begin
               held_in       = nal_byte;
               held_valid_in = 1'b1;
            end
         end
         if (last_byte && !data_end_in) begin
            if (held_valid_in) begin
               if (nq == 2'd0) begin
                  q[15:8] = held_in;
               end else begin
                  q[7:0] = held_in;
               end
               nq = nq + 2'd1;
            end
            final_in      = 1'b1;
            held_valid_in = 1'b0;
            data_end_in   = 1'b1;
         end
         shift_in = q;
         cnt_in   = {nq, 3'b000};
         flush_in = last_byte;
      end

      if (nal_end) begin
         raw_cnt_in    = 3'd0;
         zero_run_in   = 2'd0;
         seen_in       = '0;
         held_valid_in = 1'b0;
         data_end_in   = 1'b0;
         flush_in      = 1'b0;
         final_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_cnt_ff    <= 3'd0;
         zero_run_ff   <= 2'd0;
         seen_ff       <= '0;
         held_valid_ff <= 1'b0;
         data_end_ff   <= 1'b0;
         cnt_ff        <= 5'd0;
         final_ff      <= 1'b0;
         flush_ff      <= 1'b0;
      end else begin
         raw_cnt_ff    <= raw_cnt_in;
         zero_run_ff   <= zero_run_in;
         seen_ff       <= seen_in;
         held_valid_ff <= held_valid_in;
         data_end_ff   <= data_end_in;
         cnt_ff        <= cnt_in;
         final_ff      <= final_in;
         flush_ff      <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      shift_ff <= shift_in;
   end

endmodule

>>> src/sps_size_parser.sv
// Bit-serial exp-Golomb parser of the SPS syntax up to frame cropping.
// Depends on sps_size_pkg.
module sps_size_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  sps_size_pkg::bit_beat_type   beat,
   output sps_size_pkg::sps_fields_type fields
);
   import sps_size_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              is_ue_ff, is_ue_in;
   logic              suffix_ff, suffix_in;
   logic [ZERO_W-1:0] zeros_ff, zeros_in;
   logic [ZERO_W-1:0] bits_left_ff, bits_left_in;
   logic [31:0]       accum_ff, accum_in;
   logic [7:0]        profile_ff, profile_in;
   logic              cf0_ff, cf0_in, cf1_ff, cf1_in, cf3_ff, cf3_in;
   logic              sep_ff, sep_in;
   logic              frame_ff, frame_in;
   logic [31:0]       wmbs_ff, wmbs_in;
   logic [31:0]       hmap_ff, hmap_in;
   logic [3:0][31:0]  crop_ff, crop_in;
   logic [3:0]        list_idx_ff, list_idx_in;
   logic [6:0]        coef_ff, coef_in;
   logic [7:0]        scale_last_ff, scale_last_in;
   logic [CYC_W-1:0]  cyc_cnt_ff, cyc_cnt_in;
   logic [CYC_W-1:0]  cyc_idx_ff, cyc_idx_in;

   logic [31:0]       accum_sh, value;
   logic [ZERO_W-1:0] bits_dec;
   logic              finish;
   phase_type         nxt_ph;
   logic              nxt_ue;
   logic [ZERO_W-1:0] nxt_bits;
   logic [3:0]        li_next;
   logic              more_lists;
   logic [7:0]        sc_next;
   logic [6:0]        coef_next;
   logic [6:0]        list_len;
   logic [CYC_W-1:0]  ci_next;

   always_comb begin
      fields.done                = (phase_ff == PH_DONE);
      fields.sep_plane           = sep_ff;
      fields.cf_zero             = cf0_ff;
      fields.cf_one              = cf1_ff;
      fields.cf_three            = cf3_ff;
      fields.frame_only          = frame_ff;
      fields.width_in_mbs        = wmbs_ff;
      fields.height_in_map_units = hmap_ff;
      fields.crop_offsets        = crop_ff;
   end

   assign accum_sh   = {accum_ff[30:0], beat.data};
   assign bits_dec   = (bits_left_ff != '0) ? bits_left_ff - ZERO_W'(1) : '0;
   assign li_next    = list_idx_ff + 4'd1;
   assign more_lists = cf3_ff ? (li_next < 4'(LISTS_444)) : (li_next < 4'(LISTS_OTHER));
   assign coef_next  = coef_ff + 7'd1;
   assign list_len   = (list_idx_ff < 4'(SMALL_LISTS)) ? 7'(SMALL_LIST_LEN)
                                                      : 7'(LARGE_LIST_LEN);
   assign ci_next    = cyc_idx_ff + CYC_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      is_ue_in      = is_ue_ff;
      suffix_in     = suffix_ff;
      zeros_in      = zeros_ff;
      bits_left_in  = bits_left_ff;
      accum_in      = accum_ff;
      profile_in    = profile_ff;
      cf0_in        = cf0_ff;
      cf1_in        = cf1_ff;
      cf3_in        = cf3_ff;
      sep_in        = sep_ff;
      frame_in      = frame_ff;
      wmbs_in       = wmbs_ff;
      hmap_in       = hmap_ff;
      crop_in       = crop_ff;
      list_idx_in   = list_idx_ff;
      coef_in       = coef_ff;
      scale_last_in = scale_last_ff;
      cyc_cnt_in    = cyc_cnt_ff;
      cyc_idx_in    = cyc_idx_ff;
      finish        = 1'b0;
      value         = 32'd0;
      nxt_ph        = PH_DONE;
      nxt_ue        = 1'b0;
      nxt_bits      = ZERO_W'(1);
      sc_next       = 8'(scale_last_ff + se_mod256(value[8:0]));

      if (beat.valid && phase_ff != PH_DONE) begin
         if (is_ue_ff && !suffix_ff) begin
            if (!beat.data && zeros_ff < ZERO_W'(GOLOMB_ZERO_LIMIT) && !beat.last) begin
               zeros_in = zeros_ff + ZERO_W'(1);
            end else if (zeros_ff == '0) begin
               finish = 1'b1;
            end else begin
               // leading one seeds the accumulator: it ends as 2^n + suffix
               suffix_in    = 1'b1;
               bits_left_in = zeros_ff;
               accum_in     = 32'd1;
            end
         end else begin
            accum_in     = accum_sh;
            bits_left_in = bits_dec;
            if (bits_dec == '0) begin
               finish = 1'b1;
               value  = is_ue_ff ? accum_sh - 32'd1 : accum_sh;
            end
         end
      end

      sc_next = 8'(scale_last_ff + se_mod256(value[8:0]));

      if (finish) begin
         case (phase_ff)
            PH_PROFILE: begin
               profile_in = value[7:0];
               nxt_ph     = PH_CONSTR;
               nxt_bits   = ZERO_W'(8);
            end
            PH_CONSTR: begin
               nxt_ph   = PH_LEVEL;
               nxt_bits = ZERO_W'(8);
            end
            PH_LEVEL: begin
               nxt_ph = PH_SPSID;
               nxt_ue = 1'b1;
            end
            PH_SPSID: begin
               nxt_ph = is_high_profile(profile_ff) ? PH_CHROMA : PH_LOG2FN;
               nxt_ue = 1'b1;
            end
            PH_CHROMA: begin
               cf0_in = (value == 32'd0);
               cf1_in = (value == 32'd1);
               cf3_in = (value == 32'd3);
               if (value == 32'd3) begin
                  nxt_ph = PH_SEPCOL;
               end else begin
                  nxt_ph = PH_BDLUMA;
                  nxt_ue = 1'b1;
               end
            end
            PH_SEPCOL: begin
               sep_in = (value != 32'd0);
               nxt_ph = PH_BDLUMA;
               nxt_ue = 1'b1;
            end
            PH_BDLUMA: begin
               nxt_ph = PH_BDCHROMA;
               nxt_ue = 1'b1;
            end
            PH_BDCHROMA: begin
               nxt_ph = PH_BYPASS;
            end
            PH_BYPASS: begin
               nxt_ph = PH_SMPRESENT;
            end
            PH_SMPRESENT: begin
               if (value != 32'd0) begin
                  list_idx_in = 4'd0;
                  nxt_ph      = PH_LISTFLAG;
               end else begin
                  nxt_ph = PH_LOG2FN;
                  nxt_ue = 1'b1;
               end
            end
            PH_LISTFLAG: begin
               if (value != 32'd0) begin
                  coef_in       = 7'd0;
                  scale_last_in = 8'(SCALE_DEFAULT);
                  nxt_ph        = PH_DELTA;
                  nxt_ue        = 1'b1;
               end else begin
                  list_idx_in = li_next;
                  nxt_ph      = more_lists ? PH_LISTFLAG : PH_LOG2FN;
                  nxt_ue      = !more_lists;
               end
            end
            PH_DELTA: begin
               if (sc_next != 8'd0) begin
                  scale_last_in = sc_next;
               end
               coef_in = coef_next;
               if (coef_next >= list_len || sc_next == 8'd0) begin
                  list_idx_in = li_next;
                  nxt_ph      = more_lists ? PH_LISTFLAG : PH_LOG2FN;
                  nxt_ue      = !more_lists;
               end else begin
                  nxt_ph = PH_DELTA;
                  nxt_ue = 1'b1;
               end
            end
            PH_LOG2FN: begin
               nxt_ph = PH_POCTYPE;
               nxt_ue = 1'b1;
            end
            PH_POCTYPE: begin
               if (value == 32'd0) begin
                  nxt_ph = PH_POCLSB;
                  nxt_ue = 1'b1;
               end else if (value == 32'd1) begin
                  nxt_ph = PH_POCFLAG;
               end else begin
                  nxt_ph = PH_MAXREF;
                  nxt_ue = 1'b1;
               end
            end
            PH_POCLSB: begin
               nxt_ph = PH_MAXREF;
               nxt_ue = 1'b1;
            end
            PH_POCFLAG: begin
               nxt_ph = PH_POCNONREF;
               nxt_ue = 1'b1;
            end
            PH_POCNONREF: begin
               nxt_ph = PH_POCT2B;
               nxt_ue = 1'b1;
            end
            PH_POCT2B: begin
               nxt_ph = PH_POCCYC;
               nxt_ue = 1'b1;
            end
            PH_POCCYC: begin
               // saturate: only compared against the capped index
               cyc_cnt_in = (value > 32'(2 ** CYC_W - 1)) ? CYC_W'(2 ** CYC_W - 1)
                                                          : value[CYC_W-1:0];
               cyc_idx_in = '0;
               nxt_ph     = (value == 32'd0) ? PH_MAXREF : PH_POCOFF;
               nxt_ue     = 1'b1;
            end
            PH_POCOFF: begin
               cyc_idx_in = ci_next;
               nxt_ue     = 1'b1;
               if (ci_next < cyc_cnt_ff && ci_next < CYC_W'(POC_CYCLE_LIMIT)) begin
                  nxt_ph = PH_POCOFF;
               end else begin
                  nxt_ph = PH_MAXREF;
               end
            end
            PH_MAXREF: begin
               nxt_ph = PH_GAPS;
            end
            PH_GAPS: begin
               nxt_ph = PH_WMBS;
               nxt_ue = 1'b1;
            end
            PH_WMBS: begin
               wmbs_in = value + 32'd1;
               nxt_ph  = PH_HMAP;
               nxt_ue  = 1'b1;
            end
            PH_HMAP: begin
               hmap_in = value + 32'd1;
               nxt_ph  = PH_FRAMEONLY;
            end
            PH_FRAMEONLY: begin
               frame_in = value[0];
               nxt_ph   = value[0] ? PH_DIRECT8 : PH_MBAFF;
            end
            PH_MBAFF: begin
               nxt_ph = PH_DIRECT8;
            end
            PH_DIRECT8: begin
               nxt_ph = PH_CROPFLAG;
            end
            PH_CROPFLAG: begin
               if (value != 32'd0) begin
                  list_idx_in = 4'd0;
                  nxt_ph      = PH_CROP;
                  nxt_ue      = 1'b1;
               end else begin
                  nxt_ph = PH_DONE;
               end
            end
            PH_CROP: begin
               crop_in[list_idx_ff[1:0]] = value;
               list_idx_in = li_next;
               nxt_ph      = (li_next < 4'd4) ? PH_CROP : PH_DONE;
               nxt_ue      = 1'b1;
            end
            default: begin
               nxt_ph = PH_DONE;
            end
         endcase
         phase_in     = nxt_ph;
         is_ue_in     = nxt_ue;
         suffix_in    = 1'b0;
         zeros_in     = '0;
         bits_left_in = nxt_ue ? '0 : nxt_bits;
         accum_in     = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff      <= PH_PROFILE;
         is_ue_ff      <= 1'b0;
         suffix_ff     <= 1'b0;
         zeros_ff      <= '0;
         bits_left_ff  <= ZERO_W'(8);
         accum_ff      <= 32'd0;
         profile_ff    <= 8'd0;
         cf0_ff        <= 1'b0;
         cf1_ff        <= 1'b1;
         cf3_ff        <= 1'b0;
         sep_ff        <= 1'b0;
         frame_ff      <= 1'b0;
         wmbs_ff       <= 32'd0;
         hmap_ff       <= 32'd0;
         crop_ff       <= '0;
         list_idx_ff   <= 4'd0;
         coef_ff       <= 7'd0;
         scale_last_ff <= 8'(SCALE_DEFAULT);
         cyc_cnt_ff    <= '0;
         cyc_idx_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         is_ue_ff      <= is_ue_in;
         suffix_ff     <= suffix_in;
         zeros_ff      <= zeros_in;
         bits_left_ff  <= bits_left_in;
         accum_ff      <= accum_in;
         profile_ff    <= profile_in;
         cf0_ff        <= cf0_in;
         cf1_ff        <= cf1_in;
         cf3_ff        <= cf3_in;
         sep_ff        <= sep_in;
         frame_ff      <= frame_in;
         wmbs_ff       <= wmbs_in;
         hmap_ff       <= hmap_in;
         crop_ff       <= crop_in;
         list_idx_ff   <= list_idx_in;
         coef_ff       <= coef_in;
         scale_last_ff <= scale_last_in;
         cyc_cnt_ff    <= cyc_cnt_in;
         cyc_idx_ff    <= cyc_idx_in;
      end
   end

endmodule

>>> src/sps_size_calc.sv
// Crop arithmetic and result register: sizes, crop units, range checks.
// Depends on sps_size_pkg.
module sps_size_calc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         short_ok,
   input  sps_size_pkg::sps_fields_type fields,
   input  logic                         out_ready,
   output logic                         ready,
   output logic                         out_valid,
   output logic [15:0]                  pic_width,
   output logic [15:0]                  pic_height,
   output logic                         size_ok
);
   import sps_size_pkg::*;

   calc_state_type    state_ff, state_in;
   logic [SIZE_W-1:0] wid_ff, wid_in, hgt_ff, hgt_in;
   logic [SIZE_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic              ok_ff, ok_in;
   logic              valid_ff, valid_in;
   logic [15:0]       width_ff, width_in, height_ff, height_in;
   logic              size_ok_ff, size_ok_in;

   logic              unit_flat, ux_sh;
   logic [1:0]        uy_sh;
   logic [32:0]       sum_x, sum_y;
   logic [SIZE_W:0]   diff_w, diff_h;
   logic              fine;

   assign ready      = (state_ff == CALC_IDLE) && !valid_ff;
   assign out_valid  = valid_ff;
   assign pic_width  = width_ff;
   assign pic_height = height_ff;
   assign size_ok    = size_ok_ff;

   assign unit_flat = fields.sep_plane || fields.cf_zero;
   assign ux_sh     = !(unit_flat || fields.cf_three);
   assign uy_sh     = {1'b0, !fields.frame_only} + {1'b0, !unit_flat && fields.cf_one};
   assign sum_x     = {1'b0, fields.crop_offsets[0]} + {1'b0, fields.crop_offsets[1]};
   assign sum_y     = {1'b0, fields.crop_offsets[2]} + {1'b0, fields.crop_offsets[3]};
   assign diff_w    = {1'b0, wid_ff} - {1'b0, cx_ff};
   assign diff_h    = {1'b0, hgt_ff} - {1'b0, cy_ff};
   assign fine      = ok_ff && (wid_ff != '0) && (hgt_ff != '0) &&
                      (wid_ff[SIZE_W-1:16] == '0) && (hgt_ff[SIZE_W-1:16] == '0);

   always_comb begin
      state_in   = state_ff;
      wid_in     = wid_ff;
      hgt_in     = hgt_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      ok_in      = ok_ff;
      valid_in   = valid_ff && !out_ready;
      width_in   = width_ff;
      height_in  = height_ff;
      size_ok_in = size_ok_ff;
      case (state_ff)
         CALC_IDLE: begin
            if (start) begin
               wid_in   = SIZE_W'({fields.width_in_mbs, 4'b0000});
               hgt_in   = SIZE_W'({fields.height_in_map_units, 4'b0000})
                          << !fields.frame_only;
               cx_in    = SIZE_W'(sum_x) << ux_sh;
               cy_in    = SIZE_W'(sum_y) << uy_sh;
               ok_in    = short_ok;
               state_in = CALC_SUB;
            end
         end
         CALC_SUB: begin
            // a borrow means the crop consumes the picture
            ok_in    = ok_ff && !diff_w[SIZE_W] && !diff_h[SIZE_W];
            wid_in   = diff_w[SIZE_W-1:0];
            hgt_in   = diff_h[SIZE_W-1:0];
            state_in = CALC_CHECK;
         end
         CALC_CHECK: begin
            valid_in   = 1'b1;
            width_in   = fine ? wid_ff[15:0] : 16'd0;
            height_in  = fine ? hgt_ff[15:0] : 16'd0;
            size_ok_in = fine;
            state_in   = CALC_IDLE;
         end
         default: begin
            state_in = CALC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CALC_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wid_ff     <= wid_in;
      hgt_ff     <= hgt_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      ok_ff      <= ok_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      size_ok_ff <= size_ok_in;
   end

endmodule

>>> src/avc_sps_picture_size_parser_core.sv
// SPS picture size parser, top level. One NAL byte per beat on req_ch.
// A kept byte is shifted into the exp-Golomb parser one bit per cycle, and req_ch
// stays not ready while the bit shifter still holds bits of earlier bytes.
// After the last byte, the parser runs on zero bits one per cycle until the
// syntax is complete; the crop unit then subtracts and checks before the rsp_ch beat.
// Synchronous reset returns to the start of syntax; so does the end of every NAL.
`include "avc_sps_picture_size_parser_core_macros.svh"
module avc_sps_picture_size_parser_core (
   input logic           clock,
   input logic           reset,
   sps_size_req_if.sink  req_ch,
   sps_size_rsp_if.source rsp_ch
);
   import sps_size_pkg::*;

   logic           busy;
   logic           accept;
   logic           nal_end;
   logic           short_ok;
   logic           calc_ready;
   logic           rsp_nonzero;
   bit_beat_type   beat;
   sps_fields_type fields;

   assign req_ch.ready = !busy;
   assign accept       = req_ch.valid && !busy;
   assign rsp_nonzero  = (rsp_ch.pic_width != 16'd0) && (rsp_ch.pic_height != 16'd0);

   sps_size_rbsp u_rbsp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .nal_byte    (req_ch.nal_byte),
      .last_byte   (req_ch.last_byte),
      .parser_done (fields.done),
      .calc_ready  (calc_ready),
      .busy        (busy),
      .nal_end     (nal_end),
      .short_ok    (short_ok),
      .beat        (beat)
   );

   sps_size_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .restart (nal_end),
      .beat    (beat),
      .fields  (fields)
   );

   sps_size_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (nal_end),
      .short_ok   (short_ok),
      .fields     (fields),
      .out_ready  (rsp_ch.ready),
      .ready      (calc_ready),
      .out_valid  (rsp_ch.valid),
      .pic_width  (rsp_ch.pic_width),
      .pic_height (rsp_ch.pic_height),
      .size_ok    (rsp_ch.size_ok)
   );

   `SPS_ASSERT_NEVER(a_no_accept_while_shifting, clock, reset, accept && beat.valid)
   `SPS_ASSERT_IMPLY(a_end_after_parse, clock, reset, nal_end, fields.done)
   `SPS_ASSERT_IMPLY(a_end_with_free_slot, clock, reset, nal_end, !rsp_ch.valid)
   `SPS_ASSERT_IMPLY(a_ok_means_nonzero, clock, reset, rsp_ch.valid && rsp_ch.size_ok, rsp_nonzero)

endmodule
